/* hdl/cd_pkg.sv */
// ----------------------------------------------------------------------------
// cd_pkg: shared types and constants for the cosine distance block
// Accumulator widths, fixed-point constants, the vector record that passes
// from the accumulating front to the back, and the back state codes.
// ----------------------------------------------------------------------------
package cd_pkg;

	localparam int COORD_W = 16;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int ACC_W   = 48;
	localparam int ROOT_W  = ACC_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int FRAC_W  = 14;
	localparam int NUM_W   = ACC_W + FRAC_W;
	localparam int DREM_W  = ACC_W + 1;
	localparam int DIST_W  = 16;
	localparam int CNT_W   = 6;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [DIST_W:0] ONE_Q14 = (DIST_W+1)'(1) << FRAC_W;
	localparam logic [DIST_W:0] TWO_Q14 = (DIST_W+1)'(2) << FRAC_W;

	// Accumulated sums of one finished vector pair.
	typedef struct packed {
		logic signed [ACC_W-1:0] dot;
		logic signed [ACC_W-1:0] p_norm;
		logic signed [ACC_W-1:0] q_norm;
	} acc_set_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_MUL,
		ST_NUM,
		ST_DIV,
		ST_OUT
	} back_state_t;

endpackage

/* hdl/cd_front.sv */
// ----------------------------------------------------------------------------
// cd_front: coordinate pair accumulator
// Multiplies each pair into a product stage, then adds the three products
// into saturating accumulators. On the last pair the sums go to the queue
// and the accumulators clear.
// ----------------------------------------------------------------------------
module cd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [15:0]          p_coord,
	input  logic signed [15:0]          q_coord,
	input  logic                        last_pair,
	input  cd_pkg::queue_stat_t         q_stat,
	output logic                        push,
	output cd_pkg::acc_set_t            push_data
);
	import cd_pkg::*;

	logic                      valid_s1;
	logic                      last_s1;
	logic signed [PROD_W-1:0]  pq_s1, pp_s1, qq_s1;
	logic signed [ACC_W-1:0]   dot_q, pn_q, qn_q;
	logic signed [ACC_W-1:0]   dot_sum, pn_sum, qn_sum;
	logic                      blocked;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0]  acc,
		input logic signed [PROD_W-1:0] prod
	);
		logic signed [ACC_W:0] s;
		s = {acc[ACC_W-1], acc} + (ACC_W+1)'(prod);
		if (s[ACC_W] != s[ACC_W-1]) begin
			sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sat_add = s[ACC_W-1:0];
		end
	endfunction

	// A last pair waits in the product stage while the queue is full.
	assign blocked  = valid_s1 && last_s1 && q_stat.full;
	assign in_ready = !blocked;

	// Product stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!blocked) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!blocked) begin
			last_s1 <= last_pair;
			pq_s1   <= PROD_W'(p_coord * q_coord);
			pp_s1   <= PROD_W'(p_coord * p_coord);
			qq_s1   <= PROD_W'(q_coord * q_coord);
		end
	end

	// Saturating accumulation.
	always_comb begin
		dot_sum = sat_add(dot_q, pq_s1);
		pn_sum  = sat_add(pn_q, pp_s1);
		qn_sum  = sat_add(qn_q, qq_s1);
	end

	assign push             = valid_s1 && last_s1 && !q_stat.full;
	assign push_data.dot    = dot_sum;
	assign push_data.p_norm = pn_sum;
	assign push_data.q_norm = qn_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			pn_q  <= '0;
			qn_q  <= '0;
		end else if (valid_s1 && !blocked) begin
			if (last_s1) begin
				dot_q <= '0;
				pn_q  <= '0;
				qn_q  <= '0;
			end else begin
				dot_q <= dot_sum;
				pn_q  <= pn_sum;
				qn_q  <= qn_sum;
			end
		end
	end

endmodule

/* hdl/cd_queue.sv */
// ----------------------------------------------------------------------------
// cd_queue: two-entry queue of finished vector sums
// Lets the accumulator keep taking pairs while the back computes a result.
// ----------------------------------------------------------------------------
module cd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cd_pkg::acc_set_t     push_data,
	input  logic                 pop,
	output cd_pkg::acc_set_t     pop_data,
	output cd_pkg::queue_stat_t  q_stat
);
	import cd_pkg::*;

	acc_set_t   mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* hdl/cd_back.sv */
// ----------------------------------------------------------------------------
// cd_back: root, divide and output stage; a norm <= 0 skips to a zero output
// Takes one vector record at a time, forms both square roots bit by bit,
// multiplies them, divides the scaled dot magnitude by a restoring divider
// and loads the clamped distance into the output register.
// ----------------------------------------------------------------------------
module cd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cd_pkg::queue_stat_t  q_stat,
	input  cd_pkg::acc_set_t     pop_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          cos_distance,
	output logic                 zero_norm
);
	import cd_pkg::*;

	back_state_t            state_q, state_d;
	logic [CNT_W-1:0]       cnt_q;
	logic [ACC_W-1:0]       px_q, qx_q;
	logic [REM_W-1:0]       prem_q, qrem_q;
	logic [ROOT_W-1:0]      proot_q, qroot_q;
	logic [ACC_W-1:0]       mag_q;
	logic                   neg_q;
	logic                   zero_q;
	logic [ACC_W-1:0]       den_q;
	logic [NUM_W-1:0]       num_q;
	logic [DREM_W-1:0]      drem_q;
	logic [DIST_W:0]        quo_q;
	logic                   over_q;
	logic                   out_valid_q;
	logic [DIST_W-1:0]      dist_q;
	logic                   zero_out_q;

	logic [REM_W-1:0]       prem_n, qrem_n, ptrial, qtrial;
	logic [DREM_W-1:0]      drem_n;
	logic [DIST_W:0]        c_val, dist_full;
	logic                   load_out, zero_in;

	// Square root steps: two radicand bits in, one root bit out.
	always_comb begin
		prem_n = {prem_q[REM_W-3:0], px_q[ACC_W-1:ACC_W-2]};
		qrem_n = {qrem_q[REM_W-3:0], qx_q[ACC_W-1:ACC_W-2]};
		ptrial = REM_W'({proot_q, 2'b01});
		qtrial = REM_W'({qroot_q, 2'b01});
		drem_n = {drem_q[DREM_W-2:0], num_q[NUM_W-1]};
	end

	// Final clamp of the quotient and the distance.
	always_comb begin
		c_val = (over_q || quo_q > TWO_Q14) ? TWO_Q14 : quo_q;
		if (neg_q) begin
			dist_full = ONE_Q14 + c_val;
			if (dist_full > TWO_Q14) begin
				dist_full = TWO_Q14;
			end
		end else begin
			dist_full = (c_val >= ONE_Q14) ? '0 : ONE_Q14 - c_val;
		end
	end

	assign zero_in  = (pop_data.p_norm <= 0) || (pop_data.q_norm <= 0);
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					state_d = zero_in ? ST_OUT : ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_NUM;
			ST_NUM:  state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		pop = (state_q == ST_IDLE) && !q_stat.empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q    <= pop_data.p_norm;
				qx_q    <= pop_data.q_norm;
				prem_q  <= '0;
				qrem_q  <= '0;
				proot_q <= '0;
				qroot_q <= '0;
				cnt_q   <= '0;
				zero_q  <= zero_in;
				neg_q   <= pop_data.dot[ACC_W-1];
				mag_q   <= pop_data.dot[ACC_W-1] ? ACC_W'(-pop_data.dot) : pop_data.dot;
			end
			ST_ROOT: begin
				px_q  <= {px_q[ACC_W-3:0], 2'b00};
				qx_q  <= {qx_q[ACC_W-3:0], 2'b00};
				cnt_q <= cnt_q + CNT_W'(1);
				if (prem_n >= ptrial) begin
					prem_q  <= prem_n - ptrial;
					proot_q <= {proot_q[ROOT_W-2:0], 1'b1};
				end else begin
					prem_q  <= prem_n;
					proot_q <= {proot_q[ROOT_W-2:0], 1'b0};
				end
				if (qrem_n >= qtrial) begin
					qrem_q  <= qrem_n - qtrial;
					qroot_q <= {qroot_q[ROOT_W-2:0], 1'b1};
				end else begin
					qrem_q  <= qrem_n;
					qroot_q <= {qroot_q[ROOT_W-2:0], 1'b0};
				end
			end
			ST_MUL: begin
				den_q <= ACC_W'(proot_q * qroot_q);
			end
			ST_NUM: begin
				num_q  <= {mag_q, FRAC_W'(0)} + NUM_W'(den_q >> 1);
				drem_q <= '0;
				quo_q  <= '0;
				over_q <= 1'b0;
				cnt_q  <= '0;
			end
			ST_DIV: begin
				num_q  <= {num_q[NUM_W-2:0], 1'b0};
				cnt_q  <= cnt_q + CNT_W'(1);
				over_q <= over_q | quo_q[DIST_W];
				if (drem_n >= DREM_W'(den_q)) begin
					drem_q <= drem_n - DREM_W'(den_q);
					quo_q  <= {quo_q[DIST_W-1:0], 1'b1};
				end else begin
					drem_q <= drem_n;
					quo_q  <= {quo_q[DIST_W-1:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			dist_q     <= zero_q ? '0 : dist_full[DIST_W-1:0] | DIST_W'(dist_full[DIST_W]
				? TWO_Q14[DIST_W-1:0] : '0);
			zero_out_q <= zero_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign cos_distance = dist_q;
	assign zero_norm    = zero_out_q;

endmodule

/* hdl/cosine_distance.sv */
// ----------------------------------------------------------------------------
// cosine_distance: streamed cosine distance of two vectors
// Accumulates dot product and squared norms per coordinate pair and, on the
// last pair, returns one minus the cosine similarity in unsigned Q2.14.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   p_coord, q_coord, last_pair
// output    out        out_valid / out_ready cos_distance, zero_norm
//
// The front takes one coordinate pair per cycle through a product stage and
// the accumulators, except while a last pair waits on a full queue. The
// bit-serial back takes one vector at a time: 24 square root steps, one
// multiply, one numerator add and 62 divide steps. Two finished vectors can
// wait in the queue; a third last pair stalls the input. Reset clears all
// control state and the accumulators; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cosine_distance (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] p_coord,
	input  logic signed [15:0] q_coord,
	input  logic               last_pair,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        cos_distance,
	output logic               zero_norm
);
	import cd_pkg::*;

	queue_stat_t q_stat;
	acc_set_t    push_data, pop_data;
	logic        push, pop;

	cd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.p_coord   (p_coord),
		.q_coord   (q_coord),
		.last_pair (last_pair),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	cd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	cd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop_data     (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cos_distance (cos_distance),
		.zero_norm    (zero_norm)
	);

	// A zero norm always gives a zero distance.
	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> cos_distance == 16'd0)
		else $error("zero norm result with nonzero distance");

	// The distance never exceeds two.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cos_distance <= 16'd32768)
		else $error("distance above two");

	// The queue is never full and empty at once.
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue status inconsistent");

	// A push never lands on a full queue.
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

endmodule
